[design/rdfc_pkg.sv]
// Shared types, constants and the CRC8 step for the register datagram framer and checker.
package rdfc_pkg;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_RX    = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [7:0] SYNC_BYTE   = 8'h05;
   localparam logic [7:0] MASTER_ADDR = 8'hFF;
   localparam logic [7:0] CRC_POLY    = 8'h07;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_SYNC  = 3'd1;
   localparam logic [2:0] ST_BAD_MASTER = 3'd2;
   localparam logic [2:0] ST_BAD_ADDR  = 3'd3;
   localparam logic [2:0] ST_BAD_CRC   = 3'd4;

   localparam logic [3:0] WRITE_LEN = 4'd8;
   localparam logic [3:0] READ_LEN  = 4'd4;

   localparam logic [2:0] REPLY_SYNC_IDX   = 3'd0;
   localparam logic [2:0] REPLY_MASTER_IDX = 3'd1;
   localparam logic [2:0] REPLY_ADDR_IDX   = 3'd2;
   localparam logic [2:0] REPLY_CRC_IDX    = 3'd7;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_IDLE       = 2'd0,
      PH_ECHO_WRITE = 2'd1,
      PH_ECHO_READ  = 2'd2,
      PH_REPLY      = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      JOB_WRITE  = 2'd0,
      JOB_READ   = 2'd1,
      JOB_RESULT = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   node;
      logic [6:0]   addr;
      logic [31:0]  word;
      logic [2:0]   status;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (c[7] ^ b[i]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[design/rdfc_front.sv]
// Front end: accepts requests, tracks echo and reply phases, checks replies and issues jobs.
module rdfc_front
   import rdfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   input  logic        accept,
   input  logic [1:0]  command,
   input  logic [6:0]  reg_address,
   input  logic [31:0] write_value,
   input  logic [7:0]  rx_byte,
   output logic        job_push,
   output job_type     job
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  node_ff;
   logic [2:0]  byte_count_ff, byte_count_in;
   logic [3:0]  echo_left_ff, echo_left_in;
   logic [3:0]  echo_dec;
   logic [7:0]  crc_ff, crc_in;
   logic [6:0]  exp_addr_ff, exp_addr_in;
   logic [31:0] reply_ff, reply_in;
   logic [2:0]  first_err_ff, first_err_in;
   logic        err_found;
   logic [2:0]  err_code;

   assign echo_dec = (echo_left_ff != 4'd0) ? echo_left_ff - 4'd1 : 4'd0;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (command)
            CMD_WRITE: phase_in = PH_ECHO_WRITE;
            CMD_READ:  phase_in = PH_ECHO_READ;
            CMD_RX: begin
               unique case (phase_ff)
                  PH_ECHO_WRITE: if (echo_dec == 4'd0) phase_in = PH_IDLE;
                  PH_ECHO_READ:  if (echo_dec == 4'd0) phase_in = PH_REPLY;
                  PH_REPLY:      if (byte_count_ff == REPLY_CRC_IDX) phase_in = PH_IDLE;
                  PH_IDLE:       phase_in = PH_IDLE;
               endcase
            end
            CMD_NONE:  phase_in = phase_ff;
         endcase
      end
   end

   // reply checks in priority order of their byte position
   always_comb begin
      err_found = 1'b0;
      err_code  = ST_OK;
      unique case (byte_count_ff)
         REPLY_SYNC_IDX: begin
            err_found = (rx_byte != SYNC_BYTE);
            err_code  = ST_BAD_SYNC;
         end
         REPLY_MASTER_IDX: begin
            err_found = (rx_byte != MASTER_ADDR);
            err_code  = ST_BAD_MASTER;
         end
         REPLY_ADDR_IDX: begin
            err_found = (rx_byte != {1'b0, exp_addr_ff});
            err_code  = ST_BAD_ADDR;
         end
         REPLY_CRC_IDX: begin
            err_found = (rx_byte != crc_ff);
            err_code  = ST_BAD_CRC;
         end
         default: begin
            err_found = 1'b0;
            err_code  = ST_OK;
         end
      endcase
   end

   // datapath and job issue
   always_comb begin
      byte_count_in = byte_count_ff;
      echo_left_in  = echo_left_ff;
      crc_in        = crc_ff;
      exp_addr_in   = exp_addr_ff;
      reply_in      = reply_ff;
      first_err_in  = first_err_ff;
      job_push      = 1'b0;
      job.kind      = JOB_WRITE;
      job.node      = node_ff;
      job.addr      = reg_address;
      job.word      = write_value;
      job.status    = ST_OK;
      if (accept) begin
         unique case (command)
            CMD_WRITE, CMD_READ: begin
               job_push      = 1'b1;
               job.kind      = (command == CMD_WRITE) ? JOB_WRITE : JOB_READ;
               echo_left_in  = (command == CMD_WRITE) ? WRITE_LEN : READ_LEN;
               byte_count_in = 3'd0;
               crc_in        = 8'd0;
               reply_in      = 32'd0;
               first_err_in  = ST_OK;
               if (command == CMD_READ) exp_addr_in = reg_address;
            end
            CMD_RX: begin
               unique case (phase_ff)
                  PH_ECHO_WRITE, PH_ECHO_READ: begin
                     echo_left_in = echo_dec;
                     if (echo_dec == 4'd0 && phase_ff == PH_ECHO_READ) begin
                        byte_count_in = 3'd0;
                        crc_in        = 8'd0;
                        reply_in      = 32'd0;
                        first_err_in  = ST_OK;
                     end
                  end
                  PH_REPLY: begin
                     if (first_err_ff == ST_OK && err_found) first_err_in = err_code;
                     if (byte_count_ff > REPLY_ADDR_IDX && byte_count_ff < REPLY_CRC_IDX) begin
                        reply_in = {reply_ff[23:0], rx_byte};
                     end
                     if (byte_count_ff < REPLY_CRC_IDX) begin
                        crc_in        = crc8_update(crc_ff, rx_byte);
                        byte_count_in = byte_count_ff + 3'd1;
                     end else begin
                        job_push      = 1'b1;
                        job.kind      = JOB_RESULT;
                        job.node      = 8'd0;
                        job.addr      = 7'd0;
                        job.word      = (first_err_in != ST_OK) ? 32'd0 : reply_ff;
                        job.status    = first_err_in;
                        byte_count_in = 3'd0;
                        crc_in        = 8'd0;
                     end
                  end
                  PH_IDLE: begin
                     job_push = 1'b0;
                  end
               endcase
            end
            CMD_NONE: job_push = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         node_ff       <= 8'd0;
         byte_count_ff <= 3'd0;
         echo_left_ff  <= 4'd0;
         crc_ff        <= 8'd0;
         exp_addr_ff   <= 7'd0;
         reply_ff      <= 32'd0;
         first_err_ff  <= ST_OK;
      end else begin
         phase_ff      <= phase_in;
         if (csr_write_enable) node_ff <= csr_write_data;
         byte_count_ff <= byte_count_in;
         echo_left_ff  <= echo_left_in;
         crc_ff        <= crc_in;
         exp_addr_ff   <= exp_addr_in;
         reply_ff      <= reply_in;
         first_err_ff  <= first_err_in;
      end
   end

endmodule

[design/rdfc_job_queue.sv]
// Short job queue between the front end and the byte emitter.
module rdfc_job_queue
   import rdfc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head,
   output queue_status_type status
);

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_push, do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

[design/rdfc_back.sv]
// Back end: serializes datagram jobs into bytes with a running CRC and holds the result register.
module rdfc_back
   import rdfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  job_type     job,
   output logic        job_pop,
   input  logic        pop,
   output logic        empty,
   output logic        result_kind,
   output logic [7:0]  tx_byte,
   output logic        last_byte,
   output logic [31:0] read_value,
   output logic [2:0]  read_status
);

   logic [2:0]  idx_ff, idx_in;
   logic [7:0]  crc_ff, crc_in;
   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [31:0] value_ff, value_in;
   logic [2:0]  status_ff, status_in;
   logic        load, emit;
   logic [2:0]  last_idx;
   logic [7:0]  dg_byte;

   assign load     = !valid_ff || pop;
   assign last_idx = (job.kind == JOB_WRITE) ? 3'(WRITE_LEN - 4'd1) : 3'(READ_LEN - 4'd1);

   always_comb begin
      if (idx_ff == last_idx) begin
         dg_byte = crc_ff;
      end else begin
         unique case (idx_ff)
            3'd0:    dg_byte = SYNC_BYTE;
            3'd1:    dg_byte = job.node;
            3'd2:    dg_byte = {job.kind == JOB_WRITE, job.addr};
            3'd3:    dg_byte = job.word[31:24];
            3'd4:    dg_byte = job.word[23:16];
            3'd5:    dg_byte = job.word[15:8];
            default: dg_byte = job.word[7:0];
         endcase
      end
   end

   always_comb begin
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      job_pop   = 1'b0;
      emit      = 1'b0;
      kind_in   = kind_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      value_in  = value_ff;
      status_in = status_ff;
      if (job_valid && load) begin
         unique case (job.kind)
            JOB_WRITE, JOB_READ: begin
               emit      = 1'b1;
               kind_in   = 1'b0;
               byte_in   = dg_byte;
               last_in   = (idx_ff == last_idx);
               value_in  = 32'd0;
               status_in = ST_OK;
               if (idx_ff == last_idx) begin
                  job_pop = 1'b1;
                  idx_in  = 3'd0;
                  crc_in  = 8'd0;
               end else begin
                  idx_in  = idx_ff + 3'd1;
                  crc_in  = crc8_update(crc_ff, dg_byte);
               end
            end
            JOB_RESULT: begin
               emit      = 1'b1;
               job_pop   = 1'b1;
               kind_in   = 1'b1;
               byte_in   = 8'd0;
               last_in   = 1'b0;
               value_in  = job.word;
               status_in = job.status;
            end
            default: begin
               // drop an unknown job
               job_pop = 1'b1;
            end
         endcase
      end
      valid_in = emit || (valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         crc_ff   <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   assign empty       = !valid_ff;
   assign result_kind = kind_ff;
   assign tx_byte     = byte_ff;
   assign last_byte   = last_ff;
   assign read_value  = value_ff;
   assign read_status = status_ff;

endmodule

[design/register_datagram_framer_checker_top.sv]
// Top level of the register datagram framer and checker.
//
//  channel   handshake          payload
//  request   push / full        req_command, req_reg_address, req_write_value, req_rx_byte
//  response  pop / empty        rsp_result_kind, rsp_tx_byte, rsp_last_byte,
//                               rsp_read_value, rsp_read_status
//  csr       csr_write_enable   csr_write_data (node address)
//
// A request is taken while full is low; the front end updates the echo and reply state at once.
// The byte emitter drives one response byte a cycle unless the response stalls: a write
// request gives 8 bytes, a read request 4, a reply's final byte one result, other bytes none.
// Reset is synchronous and clears all phase, count and queue state; no clearing pass.
// full rises while the two-entry job queue is full; a stalled response holds its register
// and stalls the emitter, while the front end keeps working until the queue fills.
module register_datagram_framer_checker_top
   import rdfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_command,
   input  logic [6:0]  req_reg_address,
   input  logic [31:0] req_write_value,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last_byte,
   output logic [31:0] rsp_read_value,
   output logic [2:0]  rsp_read_status,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   logic             accept;
   logic             job_push;
   job_type          front_job;
   job_type          head_job;
   logic             job_pop;
   queue_status_type q_status;

   // accept a request only when the front end has room for any job it may issue
   assign full   = q_status.full;
   assign accept = push && !q_status.full;

   rdfc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .command          (req_command),
      .reg_address      (req_reg_address),
      .write_value      (req_write_value),
      .rx_byte          (req_rx_byte),
      .job_push         (job_push),
      .job              (front_job)
   );

   // hold jobs between classification and byte emission
   rdfc_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .pop      (job_pop),
      .head     (head_job),
      .status   (q_status)
   );

   // advance datagram bytes and results into the response register
   rdfc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (!q_status.empty),
      .job         (head_job),
      .job_pop     (job_pop),
      .pop         (pop),
      .empty       (empty),
      .result_kind (rsp_result_kind),
      .tx_byte     (rsp_tx_byte),
      .last_byte   (rsp_last_byte),
      .read_value  (rsp_read_value),
      .read_status (rsp_read_status)
   );

`ifndef SYNTHESIS
   a_queue_flags : assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("job queue reports full and empty together");

   a_push_room : assert property (@(posedge clock) disable iff (reset)
      job_push |-> !q_status.full)
      else $error("job issued into a full queue");

   a_pop_valid : assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !q_status.empty)
      else $error("job taken from an empty queue");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> empty)
      else $error("response present right after reset");

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_result_kind && rsp_read_status != ST_OK) |-> rsp_read_value == 32'd0)
      else $error("failed read returns a nonzero value");
`endif

endmodule
